[design/ksf_pkg.sv]
// Shared types, sizes and translation tables for the keyboard scancode FIFO.
// Used by every module of the block; depends on nothing.
package ksf_pkg;

    localparam int FIFO_DEPTH = 256;
    localparam int ADDR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int FILL_W     = 9;
    localparam int CQ_DEPTH   = 2;
    localparam int CQ_IDX_W   = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
    localparam int CQ_CNT_W   = $clog2(CQ_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_SCAN  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_RELEASE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        K_PUSH,
        K_RELEASE,
        K_READ,
        K_CLEAR,
        K_NOP
    } t_kind;

    typedef struct packed {
        logic [6:0] digit;
        logic [6:0] ascii;
    } t_entry;

    typedef struct packed {
        t_kind  kind;
        t_entry entry;
    } t_cmd;

    // US layout, scancode set 1, make codes only.
    function automatic logic [6:0] ascii_rom(input logic [6:0] code);
        logic [6:0] a;
        case (code)
            7'd1:  a = 7'h07;
            7'd2:  a = 7'h31;
            7'd3:  a = 7'h32;
            7'd4:  a = 7'h33;
            7'd5:  a = 7'h34;
            7'd6:  a = 7'h35;
            7'd7:  a = 7'h36;
            7'd8:  a = 7'h37;
            7'd9:  a = 7'h38;
            7'd10: a = 7'h39;
            7'd11: a = 7'h30;
            7'd12: a = 7'h2D;
            7'd13: a = 7'h3D;
            7'd14: a = 7'h08;
            7'd15: a = 7'h09;
            7'd16: a = 7'h71;
            7'd17: a = 7'h77;
            7'd18: a = 7'h65;
            7'd19: a = 7'h72;
            7'd20: a = 7'h74;
            7'd21: a = 7'h79;
            7'd22: a = 7'h75;
            7'd23: a = 7'h69;
            7'd24: a = 7'h6F;
            7'd25: a = 7'h70;
            7'd26: a = 7'h5B;
            7'd27: a = 7'h5D;
            7'd28: a = 7'h0A;
            7'd30: a = 7'h61;
            7'd31: a = 7'h73;
            7'd32: a = 7'h64;
            7'd33: a = 7'h66;
            7'd34: a = 7'h67;
            7'd35: a = 7'h68;
            7'd36: a = 7'h6A;
            7'd37: a = 7'h6B;
            7'd38: a = 7'h6C;
            7'd39: a = 7'h3B;
            7'd40: a = 7'h27;
            7'd41: a = 7'h60;
            7'd43: a = 7'h5C;
            7'd44: a = 7'h7A;
            7'd45: a = 7'h78;
            7'd46: a = 7'h63;
            7'd47: a = 7'h76;
            7'd48: a = 7'h62;
            7'd49: a = 7'h6E;
            7'd50: a = 7'h6D;
            7'd51: a = 7'h2C;
            7'd52: a = 7'h2E;
            7'd53: a = 7'h2F;
            7'd55: a = 7'h2A;
            7'd57: a = 7'h20;
            7'd74: a = 7'h2D;
            7'd78: a = 7'h2B;
            default: a = 7'h00;
        endcase
        return a;
    endfunction

    // F1 to F9 give the digits one to nine, F10 gives zero.
    function automatic logic [6:0] digit_rom(input logic [6:0] code);
        logic [6:0] d;
        case (code)
            7'd59: d = 7'h31;
            7'd60: d = 7'h32;
            7'd61: d = 7'h33;
            7'd62: d = 7'h34;
            7'd63: d = 7'h35;
            7'd64: d = 7'h36;
            7'd65: d = 7'h37;
            7'd66: d = 7'h38;
            7'd67: d = 7'h39;
            7'd68: d = 7'h30;
            default: d = 7'h00;
        endcase
        return d;
    endfunction

endpackage

[design/keyboard_scancode_fifo_unit.sv]
// Top level of the keyboard scancode FIFO: decoder, command queue and FIFO engine.
// Depends on ksf_pkg, ksf_front, ksf_cmd_queue and ksf_back.
//
//   channel   handshake        accepted when      payload
//   command   push / full      push && !full      i_opcode, i_scan_code
//   result    empty / pop      pop && !empty      o_char_code, o_function_digit,
//                                                 o_status, o_fill_count
//
// One command is taken per cycle while full is low; the engine issues one command a
// cycle from the two-entry queue while the result register is free or being popped.
// A command is registered in the queue before it issues, and its result, store read
// included, is registered onto the ports at the edge that issues it.
// Reset is synchronous and leaves the FIFO empty; the store itself is not cleared.
// A stalled result holds the engine, and full rises once the command queue fills.
module keyboard_scancode_fifo_unit import ksf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_scan_code,
    output logic              empty,
    input  logic              pop,
    output logic [6:0]        o_char_code,
    output logic [6:0]        o_function_digit,
    output logic [1:0]        o_status,
    output logic [FILL_W-1:0] o_fill_count
);

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic q_push;
    logic q_full;
    logic q_valid;
    logic eng_ready;

    assign full = q_full;

    ksf_front u_front (
        .i_push       (push),
        .i_opcode     (i_opcode),
        .i_scan_code  (i_scan_code),
        .i_queue_full (q_full),
        .o_queue_push (q_push),
        .o_cmd        (front_cmd)
    );

    ksf_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_ready (eng_ready)
    );

    ksf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (q_valid),
        .i_cmd            (head_cmd),
        .o_ready          (eng_ready),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_char_code      (o_char_code),
        .o_function_digit (o_function_digit),
        .o_status         (o_status),
        .o_fill_count     (o_fill_count)
    );

endmodule

[design/ksf_front.sv]
// Front end: decodes each transaction and translates key presses through the ROMs.
// Depends on ksf_pkg.
module ksf_front import ksf_pkg::*; (
    input  logic       i_push,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_scan_code,
    input  logic       i_queue_full,
    output logic       o_queue_push,
    output t_cmd       o_cmd
);

    always_comb begin
        o_cmd.entry.ascii = ascii_rom(i_scan_code[6:0]);
        o_cmd.entry.digit = digit_rom(i_scan_code[6:0]);
        case (t_opcode'(i_opcode))
            OP_SCAN:  o_cmd.kind = i_scan_code[7] ? K_RELEASE : K_PUSH;
            OP_READ:  o_cmd.kind = K_READ;
            OP_CLEAR: o_cmd.kind = K_CLEAR;
            default:  o_cmd.kind = K_NOP;
        endcase
    end

    assign o_queue_push = i_push && !i_queue_full;

endmodule

[design/ksf_cmd_queue.sv]
// Short command queue between the decoder and the FIFO engine.
// Depends on ksf_pkg.
module ksf_cmd_queue import ksf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_ready
);

    t_cmd                r_slot [CQ_DEPTH];
    logic [CQ_IDX_W-1:0] r_wr, n_wr;
    logic [CQ_IDX_W-1:0] r_rd, n_rd;
    logic [CQ_CNT_W-1:0] r_cnt, n_cnt;
    logic                take;

    assign o_full  = (r_cnt == CQ_CNT_W'(CQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rd];
    assign take    = o_valid && i_ready;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == CQ_IDX_W'(CQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (take) begin
            n_rd = (r_rd == CQ_IDX_W'(CQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !take) begin
            n_cnt = r_cnt + 1'b1;
        end else if (take && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CQ_CNT_W'(CQ_DEPTH))
        else $error("command queue holds more than its depth");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("command written into a full queue");

    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_cmd)))
        else $error("queue head changed while the engine stalled");

endmodule

[design/ksf_back.sv]
// FIFO engine: carries out queued commands on the character store and holds the result.
// Depends on ksf_pkg.
module ksf_back import ksf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_cmd              i_cmd,
    output logic              o_ready,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [6:0]        o_char_code,
    output logic [6:0]        o_function_digit,
    output logic [1:0]        o_status,
    output logic [FILL_W-1:0] o_fill_count
);

    t_entry            r_store [FIFO_DEPTH];
    t_entry            r_rd_data;
    logic [ADDR_W-1:0] r_wp, n_wp;
    logic [ADDR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid;
    logic              r_read_ok;
    t_status           r_status;
    logic [FILL_W-1:0] r_fill;
    t_status           status;
    logic              issue;
    logic              do_write;
    logic              do_read;
    logic [CNT_W:0]    chk_sum;

    // The result register is free when empty or being taken in this cycle.
    assign o_ready = !r_out_valid || i_pop;
    assign issue   = i_valid && o_ready;

    always_comb begin
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_count  = r_count;
        status   = ST_OK;
        do_write = 1'b0;
        do_read  = 1'b0;
        case (i_cmd.kind)
            K_PUSH: begin
                if (r_count == CNT_W'(FIFO_DEPTH)) begin
                    status = ST_FULL;
                end else begin
                    do_write = issue;
                    n_wp     = (r_wp == ADDR_W'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end
            K_RELEASE: status = ST_RELEASE;
            K_READ: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else begin
                    do_read = issue;
                    n_rp    = (r_rp == ADDR_W'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            K_CLEAR: begin
                n_wp    = '0;
                n_rp    = '0;
                n_count = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_wp    <= n_wp;
                r_rp    <= n_rp;
                r_count <= n_count;
            end
            if (issue) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_read_ok <= do_read;
            r_status  <= status;
            r_fill    <= FILL_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_store[r_wp] <= i_cmd.entry;
        end
        if (do_read) begin
            r_rd_data <= r_store[r_rp];
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_char_code      = r_read_ok ? r_rd_data.ascii : 7'd0;
    assign o_function_digit = r_read_ok ? r_rd_data.digit : 7'd0;
    assign o_status         = r_status;
    assign o_fill_count     = r_fill;

    assign chk_sum = {1'b0, r_count} + (CNT_W + 1)'(r_rp);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("entry count beyond the FIFO depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && i_cmd.kind == K_CLEAR) |=>
            (r_count == '0 && r_wp == '0 && r_rp == '0 && r_fill == '0))
        else $error("clear did not empty the FIFO");

    a_pointer_coherent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((chk_sum >= (CNT_W + 1)'(FIFO_DEPTH)) ?
            (chk_sum - (CNT_W + 1)'(FIFO_DEPTH)) == (CNT_W + 1)'(r_wp) :
            chk_sum == (CNT_W + 1)'(r_wp)))
        else $error("read pointer and count disagree with write pointer");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_status) && $stable(r_fill)))
        else $error("waiting result changed before it was taken");

endmodule
